// File: hw/rtl/kmp_substring_counter_assert.svh
// assertion macros used by the kmp substring counter checker
`ifndef KMP_SUBSTRING_COUNTER_ASSERT_SVH
`define KMP_SUBSTRING_COUNTER_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define KSC_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while dis is high
`define KSC_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/kmpsc_pkg.sv
// shared types and constants of the kmp substring counter
package kmpsc_pkg;

  // default sizing
  localparam int MAX_PATTERN_DEF = 64;
  localparam int COUNT_BITS_DEF  = 32;

  // stream payload layout
  localparam int IN_BYTE_W   = 8;
  localparam int OUT_COUNT_W = 32;
  localparam int OUT_DATA_W  = 40;

  // request kind carried on s_tuser
  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } kmpsc_state_t;

endpackage

// File: hw/rtl/kmp_substring_counter.sv
// kmp substring counter: pattern load with online failure table, text scan
//
//  channel | dir | tdata                         | tuser        | tlast
//  --------+-----+-------------------------------+--------------+----------
//  s_*     | in  | [7:0] byte_value              | func         | last
//  m_*     | out | [0] match_here [32:1] count   | overflow     | text_done
//
// the first pattern byte of a pattern and a pattern byte past capacity are done in the idle state;
// other pattern bytes and text requests with a usable pattern go through the scan state, which
// repeats per failure-table backtrack step (one read of the pattern and failure rams per cycle);
// amortized under 2 backtracks. a text request with no usable pattern goes to the emit state.
// synchronous reset clears all control state; the rams need no clearing.
// a stalled result register holds the scan of a text request in its last step.
module kmp_substring_counter #(
  parameter int MAX_PATTERN = kmpsc_pkg::MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = kmpsc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [kmpsc_pkg::IN_BYTE_W-1:0]     s_tdata,   // [7:0] byte_value
  input  logic                                s_tuser,   // [0] func
  input  logic                                s_tlast,   // last
  // master side
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [kmpsc_pkg::OUT_DATA_W-1:0]    m_tdata,   // [0] match_here, [32:1] match_count
  output logic                                m_tuser,   // [0] overflow
  output logic                                m_tlast    // text_done
);

  import kmpsc_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W = $clog2(MAX_PATTERN);

  kmpsc_state_t state, state_next;

  // request held during the scan
  logic                  item_func;
  logic [IN_BYTE_W-1:0]  item_byte;
  logic                  item_last;
  logic [LEN_W-1:0]      pos;

  // block state
  logic [LEN_W-1:0]      pat_len;
  logic [LEN_W-1:0]      build_pos;
  logic [LEN_W-1:0]      match_pos;
  logic [COUNT_BITS-1:0] count;
  logic                  closed;
  logic                  ovf;

  // ram ports
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [IN_BYTE_W-1:0]  pat_wdata;
  logic [LEN_W-1:0]      fail_wdata;
  logic [ADDR_W-1:0]     pat_raddr;
  logic [ADDR_W-1:0]     fail_raddr;
  logic [IN_BYTE_W-1:0]  pat_rdata;
  logic [LEN_W-1:0]      fail_rdata;

  // datapath
  logic                  accept;
  logic [LEN_W-1:0]      eff_len;
  logic [LEN_W-1:0]      bld_start;
  logic [LEN_W-1:0]      txt_start;
  logic [LEN_W-1:0]      start_pos;
  logic                  pat_full;
  logic                  scan_ok;
  logic                  pat_eq;
  logic                  back;
  logic [LEN_W-1:0]      fail_k;
  logic [LEN_W-1:0]      pos_end;
  logic                  hit;
  logic                  out_free;
  logic                  finish;
  logic                  emit_scan;
  logic                  emit_plain;
  logic [LEN_W-1:0]      rd_pos;
  logic [LEN_W-1:0]      rd_prev;
  logic [COUNT_BITS-1:0] cnt_new;

  // request side
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // start points of the advance loop
  assign eff_len   = closed ? '0 : pat_len;
  assign bld_start = (build_pos < eff_len) ? build_pos : '0;
  assign txt_start = (match_pos < pat_len) ? match_pos : '0;
  assign start_pos = (s_tuser == FUNC_PATTERN) ? bld_start : txt_start;
  assign pat_full  = (eff_len >= LEN_W'(MAX_PATTERN));
  assign scan_ok   = (pat_len != '0) && !ovf;

  // compare step on ram data
  assign pat_eq   = (pat_rdata == item_byte);
  assign back     = (pos != '0) && !pat_eq;
  assign fail_k   = (fail_rdata < pos) ? fail_rdata : '0;
  assign pos_end  = pos + LEN_W'(pat_eq);
  assign hit      = (pos_end >= pat_len);
  assign out_free = !m_tvalid || m_tready;

  assign finish     = (state == ST_SCAN) && !back &&
                      ((item_func == FUNC_PATTERN) || out_free);
  assign emit_scan  = finish && (item_func == FUNC_TEXT);
  assign emit_plain = (state == ST_EMIT) && out_free;

  assign cnt_new = (hit && (count != {COUNT_BITS{1'b1}})) ? count + 1'b1 : count;

  // read address: start on accept, follow the failure link on backtrack
  always_comb begin
    priority if (state == ST_IDLE) begin
      rd_pos = start_pos;
    end else if ((state == ST_SCAN) && back) begin
      rd_pos = fail_k;
    end else begin
      rd_pos = pos;
    end
  end

  assign rd_prev    = rd_pos - 1'b1;
  assign pat_raddr  = rd_pos[ADDR_W-1:0];
  assign fail_raddr = (rd_pos == '0) ? '0 : rd_prev[ADDR_W-1:0];

  // write: first pattern byte straight from the port, others after the scan
  assign wr_en = (accept && (s_tuser == FUNC_PATTERN) && !pat_full && (eff_len == '0)) ||
                 (finish && (item_func == FUNC_PATTERN));
  assign wr_addr    = (state == ST_IDLE) ? '0 : pat_len[ADDR_W-1:0];
  assign pat_wdata  = (state == ST_IDLE) ? s_tdata : item_byte;
  assign fail_wdata = (state == ST_IDLE) ? '0 : pos_end;

  kmpsc_ram #(
    .WIDTH (IN_BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_pat_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (pat_wdata),
    .rd_addr (pat_raddr),
    .rd_data (pat_rdata)
  );

  kmpsc_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_PATTERN)
  ) u_fail_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (fail_wdata),
    .rd_addr (fail_raddr),
    .rd_data (fail_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == FUNC_PATTERN) begin
            state_next = (!pat_full && (eff_len != '0)) ? ST_SCAN : ST_IDLE;
          end else begin
            state_next = scan_ok ? ST_SCAN : ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and scan position
  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= s_tuser;
      item_byte <= s_tdata;
      item_last <= s_tlast;
      pos       <= start_pos;
    end else if ((state == ST_SCAN) && back) begin
      pos <= fail_k;
    end
  end

  // pattern, match and count state
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      build_pos <= '0;
      match_pos <= '0;
      count     <= '0;
      closed    <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      if (accept && (s_tuser == FUNC_PATTERN)) begin
        // a closed pattern is dropped before the new one starts
        if (closed) begin
          pat_len   <= '0;
          build_pos <= '0;
          match_pos <= '0;
          count     <= '0;
          ovf       <= 1'b0;
        end
        if (pat_full) begin
          ovf <= 1'b1;
        end else if (eff_len == '0) begin
          pat_len   <= LEN_W'(1);
          build_pos <= '0;
        end
        closed <= s_tlast;
      end else if (accept) begin
        closed <= 1'b1;
      end
      // pattern byte extends the failure table
      if (finish && (item_func == FUNC_PATTERN)) begin
        pat_len   <= pat_len + 1'b1;
        build_pos <= pos_end;
      end
      // text byte result, positions reset after the last byte
      if (emit_scan) begin
        match_pos <= item_last ? '0 : (hit ? build_pos : pos_end);
        count     <= item_last ? '0 : cnt_new;
      end else if (emit_plain && item_last) begin
        match_pos <= '0;
        count     <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_scan || emit_plain) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_scan) begin
      m_tdata <= {(OUT_DATA_W - OUT_COUNT_W - 1)'(0), OUT_COUNT_W'(cnt_new), hit};
      m_tlast <= item_last;
      m_tuser <= ovf;
    end else if (emit_plain) begin
      m_tdata <= {(OUT_DATA_W - OUT_COUNT_W - 1)'(0), OUT_COUNT_W'(count), 1'b0};
      m_tlast <= item_last;
      m_tuser <= ovf;
    end
  end

endmodule

// File: hw/rtl/kmpsc_ram.sv
// generic single-write, single-read ram with registered read data
module kmpsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/kmpsc_checker.sv
// port-level checker of the kmp substring counter, bound to the top level
`include "kmp_substring_counter_assert.svh"

module kmpsc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                s_tuser,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [kmpsc_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                                m_tuser,
  input logic                                m_tlast
);

  import kmpsc_pkg::*;

  // a stalled result keeps its payload
  `KSC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")

  // an overflowed pattern never matches
  `KSC_ASSERT_NOW(a_no_match_on_ovf, clk, rst, m_tvalid && m_tuser, !m_tdata[0], "match reported with overflowed pattern")

  // reset leaves no result pending
  `KSC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "result valid after reset")

  // padding bits of the result stay zero
  `KSC_ASSERT_NOW(a_pad_zero, clk, rst, m_tvalid, m_tdata[OUT_DATA_W-1:OUT_COUNT_W+1] == '0, "result padding not zero")

  // after a text request is taken, the block leaves the idle state and drops s_tready
  `KSC_ASSERT_NEXT(a_busy_after_text, clk, rst, s_tvalid && s_tready && (s_tuser == FUNC_TEXT), !s_tready, "request taken right after a text request")

endmodule

bind kmp_substring_counter kmpsc_checker u_kmpsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
